@@ rtl/core/p2pa_pkg.sv @@
`default_nettype none

package p2pa_pkg;

    localparam int SLOT_W    = 10;
    localparam int CAP_LIMIT = 1023;
    localparam int BYTES_W   = 23;
    localparam int CLASS_W   = 6;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_CLASS = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FREE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        WR_ALLOC = 2'd0,
        WR_FREE  = 2'd1,
        WR_CLEAR = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    round;
        logic    classify;
        logic    setup;
        logic    step;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    finish;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic no_class;
        logic out_range;
        logic is_free;
        logic hit;
        logic last;
        logic in_word;
        logic bit_busy;
        logic clear_last;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/p2pa_ctrl.sv @@
`default_nettype none

module p2pa_ctrl
    import p2pa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROUND,
        S_CLASS,
        S_SETUP,
        S_READ,
        S_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        o_cmd.wr_sel = WR_CLEAR;
        o_cmd.code   = ST_OK;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.step  = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                priority if (i_stat.no_class) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_NO_CLASS;
                    n_state = S_IDLE;
                end else if (i_stat.is_free && i_stat.out_range) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.code   = ST_RANGE;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_stat.is_free) begin
                    priority if (i_stat.hit) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_ALLOC;
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_OK;
                        n_state = S_IDLE;
                    end else if (i_stat.last) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = S_READ;
                    end
                end else begin
                    priority if (i_stat.in_word && i_stat.bit_busy) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_FREE;
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_OK;
                        n_state = S_IDLE;
                    end else if (i_stat.in_word) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.code   = ST_FREE;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/p2pa_dpath.sv @@
`default_nettype none

module p2pa_dpath
    import p2pa_pkg::*;
#(
    parameter int NUM_CLASSES   = 23,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic               i_req_type,
    input  wire logic [31:0]        i_req_size,
    input  wire logic [4:0]         i_align_log2,
    input  wire logic [SLOT_W-1:0]  i_slot_index,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic [4:0]              o_size_class,
    output logic [SLOT_W-1:0]       o_granted_slot,
    output logic [BYTES_W-1:0]      o_granted_bytes
);

    localparam int WPC    = (CAP_LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int TOTAL  = NUM_CLASSES * WPC;
    localparam int AW     = $clog2(TOTAL);
    localparam int BW     = $clog2(MAP_WORD_BITS);
    localparam int OFF_W  = SLOT_W + 1;
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TBL_N  = 2 ** CLS_W;
    localparam logic [OFF_W-1:0] W_OFF = OFF_W'(MAP_WORD_BITS);

    function automatic logic [TBL_N*SLOT_W-1:0] f_caps();
        logic [TBL_N*SLOT_W-1:0] t;
        int n;
        t = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n = ((NUM_CLASSES - c) * NUM_CLASSES * 3) / 2;
            if (n > CAP_LIMIT) n = CAP_LIMIT;
            t[c*SLOT_W +: SLOT_W] = SLOT_W'(n);
        end
        return t;
    endfunction

    function automatic logic [TBL_N*AW-1:0] f_bases();
        logic [TBL_N*AW-1:0] t;
        int n;
        int acc;
        t = '0;
        acc = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            t[c*AW +: AW] = AW'(acc);
            n = ((NUM_CLASSES - c) * NUM_CLASSES * 3) / 2;
            if (n > CAP_LIMIT) n = CAP_LIMIT;
            acc = acc + (n + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
        end
        return t;
    endfunction

    localparam logic [TBL_N*SLOT_W-1:0] CAP_TAB  = f_caps();
    localparam logic [TBL_N*AW-1:0]     BASE_TAB = f_bases();

    logic                     r_type;
    logic [31:0]              r_size;
    logic [4:0]               r_align;
    logic [SLOT_W-1:0]        r_idx;
    logic [32:0]              r_round;
    logic [CLASS_W-1:0]       r_cls;
    logic [SLOT_W-1:0]        r_cap;
    logic [AW-1:0]            r_addr;
    logic [OFF_W-1:0]         r_off;
    logic [MAP_WORD_BITS-1:0] r_rdata;
    logic [MAP_WORD_BITS-1:0] mem [TOTAL];

    logic                     r_done;
    t_status                  r_status;
    logic [4:0]               r_class_out;
    logic [SLOT_W-1:0]        r_slot_out;
    logic [BYTES_W-1:0]       r_bytes_out;

    logic [32:0]              n_round;
    logic [32:0]              mask33;
    logic [32:0]              rm1;
    logic [CLASS_W-1:0]       n_cls;
    logic [CLS_W-1:0]         cls_i;
    logic [SLOT_W-1:0]        cap_now;
    logic [OFF_W-1:0]         lim;
    logic [OFF_W-1:0]         left;
    logic [MAP_WORD_BITS-1:0] free_bits;
    logic [BW-1:0]            pos;
    logic [OFF_W-1:0]         rel;
    logic [BW-1:0]            bitpos;
    logic [OFF_W-1:0]         off_next;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic [SLOT_W-1:0]        alloc_slot;
    logic [BYTES_W-1:0]       bytes_now;

    always_comb begin
        mask33  = (33'd1 << r_align) - 33'd1;
        n_round = ({1'b0, r_size} + mask33) & ~mask33;
        rm1     = r_round - 33'd1;
        n_cls   = '0;
        for (int i = 0; i < 33; i++) begin
            if (rm1[i]) n_cls = CLASS_W'(i + 1);
        end
        if (r_round <= 33'd1) n_cls = '0;
    end

    assign cls_i   = r_cls[CLS_W-1:0];
    assign cap_now = CAP_TAB[cls_i*SLOT_W +: SLOT_W];

    always_comb begin
        left = {1'b0, r_cap} - r_off;
        lim  = (left > W_OFF) ? W_OFF : left;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            free_bits[b] = ~r_rdata[b] & (OFF_W'(b) < lim);
        end
        pos = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) pos = BW'(b);
        end
    end

    assign off_next   = r_off + W_OFF;
    assign rel        = {1'b0, r_idx} - r_off;
    assign bitpos     = rel[BW-1:0];
    assign alloc_slot = SLOT_W'(r_off + OFF_W'(pos));
    assign bytes_now  = (r_cls < CLASS_W'(BYTES_W)) ?
                        (BYTES_W'(1) << r_cls[4:0]) : '0;

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_ALLOC: wdata = r_rdata | (MAP_WORD_BITS'(1) << pos);
            WR_FREE:  wdata = r_rdata & ~(MAP_WORD_BITS'(1) << bitpos);
            default:  wdata = '0;
        endcase
    end

    always_comb begin
        o_stat.no_class   = (r_cls >= CLASS_W'(NUM_CLASSES));
        o_stat.out_range  = (r_idx >= cap_now);
        o_stat.is_free    = r_type;
        o_stat.hit        = |free_bits;
        o_stat.last       = (off_next >= {1'b0, r_cap});
        o_stat.in_word    = ({1'b0, r_idx} < off_next);
        o_stat.bit_busy   = r_rdata[bitpos];
        o_stat.clear_last = (r_addr == AW'(TOTAL - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_addr] <= wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_size  <= i_req_size;
            r_align <= i_align_log2;
            r_idx   <= i_slot_index;
        end
        if (i_cmd.round) r_round <= n_round;
        if (i_cmd.classify) r_cls <= n_cls;
        if (i_cmd.setup) r_cap <= cap_now;
        if (i_cmd.finish) begin
            r_status <= i_cmd.code;
            r_class_out <= (i_cmd.code == ST_NO_CLASS) ? 5'd0 : r_cls[4:0];
            r_bytes_out <= '0;
            priority if (i_cmd.code == ST_OK && !r_type) begin
                r_slot_out  <= alloc_slot;
                r_bytes_out <= bytes_now;
            end else if (r_type) begin
                r_slot_out <= r_idx;
            end else begin
                r_slot_out <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_off  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.setup) begin
                r_addr <= BASE_TAB[cls_i*AW +: AW];
                r_off  <= '0;
            end else if (i_cmd.step) begin
                r_addr <= r_addr + AW'(1);
                r_off  <= off_next;
            end
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_size_class    = r_class_out;
    assign o_granted_slot  = r_slot_out;
    assign o_granted_bytes = r_bytes_out;

endmodule

`default_nettype wire

@@ rtl/core/pow2_size_class_pool_allocator.sv @@
`default_nettype none

// Power-of-two size class pool allocator, slot bookkeeping only.
// A request is taken when start is high and busy is low. It carries the type
// (allocate or free), the size, the alignment and, for a free, the slot index.
// The size is rounded up to the alignment and then to a power of two to pick
// the class. An allocate takes the lowest free slot of that class, and a free
// releases the given slot. Each request gives exactly one result, shown for
// one cycle with o_done high; the receiver cannot stall it.
// A request that fails its class or index check ends without reading the
// bitmap; otherwise the bitmap words of its class are read one after another
// until the answer is known. One request is in flight at a time, and the next
// can be accepted in the cycle that o_done is shown.
// After reset the bitmap memory is cleared one word per cycle, all
// NUM_CLASSES * ceil(1023 / MAP_WORD_BITS) words (368 by default); busy is
// high during that pass.

module pow2_size_class_pool_allocator
    import p2pa_pkg::*;
#(
    parameter int NUM_CLASSES   = 23,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_req_type,
    input  wire logic [31:0]        i_req_size,
    input  wire logic [4:0]         i_align_log2,
    input  wire logic [SLOT_W-1:0]  i_slot_index,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic [4:0]              o_size_class,
    output logic [SLOT_W-1:0]       o_granted_slot,
    output logic [BYTES_W-1:0]      o_granted_bytes
);

    t_cmd  cmd;
    t_stat stat;

    p2pa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    p2pa_dpath #(
        .NUM_CLASSES   (NUM_CLASSES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_req_size      (i_req_size),
        .i_align_log2    (i_align_log2),
        .i_slot_index    (i_slot_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_size_class    (o_size_class),
        .o_granted_slot  (o_granted_slot),
        .o_granted_bytes (o_granted_bytes)
    );

endmodule

`default_nettype wire

@@ tb/pow2_size_class_pool_allocator_tb.sv @@
`timescale 1ns / 1ps

module pow2_size_class_pool_allocator_tb;
    import p2pa_pkg::*;

    localparam int NCLS       = 23;
    localparam int WBITS      = 64;
    localparam int ITEMS      = 1950;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         size_class;
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] bytes;
    } t_result;

    typedef struct {
        logic               req_type;
        logic [31:0]        size;
        logic [4:0]         align;
        logic [SLOT_W-1:0]  idx;
        logic               has_exp;
        t_result            exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_req_type = 1'b0;
    logic [31:0] i_req_size = '0;
    logic [4:0] i_align_log2 = '0;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic o_done;
    logic [2:0] o_status;
    logic [4:0] o_size_class;
    logic [SLOT_W-1:0] o_granted_slot;
    logic [BYTES_W-1:0] o_granted_bytes;

    pow2_size_class_pool_allocator #(.NUM_CLASSES(NCLS), .MAP_WORD_BITS(WBITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_req_size(i_req_size), .i_align_log2(i_align_log2),
        .i_slot_index(i_slot_index), .o_done(o_done), .o_status(o_status),
        .o_size_class(o_size_class), .o_granted_slot(o_granted_slot),
        .o_granted_bytes(o_granted_bytes)
    );

    always #5 i_clk = ~i_clk;

    bit      slot_taken [NCLS][CAP_LIMIT];
    int      free_left [NCLS];
    t_result pending_results [$];
    int      errors = 0;
    int      cycles = 0;

    function automatic int capacity_of(int c);
        int n;
        n = ((NCLS - c) * NCLS * 3) / 2;
        return n > CAP_LIMIT ? CAP_LIMIT : n;
    endfunction

    function automatic int class_for(logic [31:0] size, logic [4:0] a);
        logic [63:0] mask;
        logic [63:0] r;
        int c;
        mask = (64'd1 << a) - 64'd1;
        r = ({32'd0, size} + mask) & ~mask;
        c = 0;
        while (c < 40 && (64'd1 << c) < r) c++;
        return c;
    endfunction

    function automatic t_result allocate_or_free(logic rt, logic [31:0] size,
                                                 logic [4:0] a, logic [SLOT_W-1:0] idx);
        t_result res;
        int c;
        int cap;
        c = class_for(size, a);
        res.status = ST_OK;
        res.slot = rt ? idx : '0;
        res.bytes = '0;
        if (c >= NCLS) begin
            res.status = ST_NO_CLASS;
            c = 0;
        end else begin
            cap = capacity_of(c);
            if (!rt) begin
                if (free_left[c] == 0) begin
                    res.status = ST_FULL;
                end else begin
                    res.status = ST_FULL;
                    for (int s = 0; s < cap; s++) begin
                        if (!slot_taken[c][s]) begin
                            slot_taken[c][s] = 1'b1;
                            res.slot = s[SLOT_W-1:0];
                            res.status = ST_OK;
                            break;
                        end
                    end
                    if (res.status == ST_OK) begin
                        free_left[c]--;
                        res.bytes = BYTES_W'(64'd1 << c);
                    end
                end
            end else if (idx >= cap) begin
                res.status = ST_RANGE;
            end else if (!slot_taken[c][idx]) begin
                res.status = ST_FREE;
            end else begin
                slot_taken[c][idx] = 1'b0;
                if (free_left[c] < cap) free_left[c]++;
            end
        end
        res.size_class = c[4:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                t_result e;
                e = pending_results.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", int'(o_status), int'(e.status));
                if (o_size_class !== e.size_class)
                    report_mismatch("size_class", int'(o_size_class), int'(e.size_class));
                if (o_granted_slot !== e.slot)
                    report_mismatch("granted_slot", int'(o_granted_slot), int'(e.slot));
                if (o_granted_bytes !== e.bytes)
                    report_mismatch("granted_bytes", int'(o_granted_bytes), int'(e.bytes));
            end
        end
    end

    task automatic send_request(logic rt, logic [31:0] size, logic [4:0] a,
                                logic [SLOT_W-1:0] idx, bit has_exp, t_result want);
        t_result got;
        start <= 1'b1;
        i_req_type <= rt;
        i_req_size <= size;
        i_align_log2 <= a;
        i_slot_index <= idx;
        do @(posedge i_clk); while (busy);
        got = allocate_or_free(rt, size, a, idx);
        if (has_exp) begin
            if (got.status !== want.status)
                report_mismatch("table status", int'(got.status), int'(want.status));
            if (got.size_class !== want.size_class)
                report_mismatch("table size_class", int'(got.size_class),
                                int'(want.size_class));
            if (got.slot !== want.slot)
                report_mismatch("table granted_slot", int'(got.slot), int'(want.slot));
            if (got.bytes !== want.bytes)
                report_mismatch("table granted_bytes", int'(got.bytes), int'(want.bytes));
        end
        pending_results.push_back(got);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    t_row rows [$];

    function automatic t_row mk(logic rt, logic [31:0] sz, logic [4:0] a,
                                logic [SLOT_W-1:0] idx, bit he,
                                logic [2:0] st, logic [4:0] c,
                                logic [SLOT_W-1:0] sl, logic [BYTES_W-1:0] by);
        t_row r;
        r.req_type = rt; r.size = sz; r.align = a; r.idx = idx; r.has_exp = he;
        r.exp = '{st, c, sl, by};
        return r;
    endfunction

    initial begin
        int c;
        int s;
        logic rt;
        logic [31:0] sz;
        logic [4:0] a;
        for (int k = 0; k < NCLS; k++) begin
            free_left[k] = capacity_of(k);
            for (int j = 0; j < CAP_LIMIT; j++) slot_taken[k][j] = 1'b0;
        end
        rows.push_back(mk(0, 0, 0, 0, 1, ST_OK, 0, 0, 1));
        rows.push_back(mk(0, 1, 0, 0, 1, ST_OK, 0, 1, 1));
        rows.push_back(mk(0, 32'hFFFF_FFFF, 0, 0, 1, ST_NO_CLASS, 0, 0, 0));
        rows.push_back(mk(1, 32'hFFFF_FFFF, 31, 1023, 1, ST_NO_CLASS, 0, 1023, 0));
        rows.push_back(mk(0, 32'h0040_0000, 0, 0, 1, ST_OK, 22, 0, 23'h40_0000));
        rows.push_back(mk(0, 32'h0040_0000, 0, 0, 1, ST_OK, 22, 1, 23'h40_0000));
        rows.push_back(mk(0, 32'h0040_0000, 0, 0, 1, ST_OK, 22, 2, 23'h40_0000));
        rows.push_back(mk(1, 32'h0040_0000, 0, 34, 1, ST_RANGE, 22, 34, 0));
        rows.push_back(mk(1, 32'h0040_0000, 0, 1, 1, ST_OK, 22, 1, 0));
        rows.push_back(mk(1, 32'h0040_0000, 0, 1, 1, ST_FREE, 22, 1, 0));
        rows.push_back(mk(0, 3, 3, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 5, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 1, 22, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 31, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 0, 0, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 0, 0, 1023, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 32'h0040_0001, 0, 0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_request(rows[k].req_type, rows[k].size, rows[k].align, rows[k].idx,
                         rows[k].has_exp, rows[k].exp);
            idle_gap();
        end

        for (int n = 0; n < ITEMS; n++) begin
            // Mostly small target classes (0 to 5), else a large one (14 to 22).
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                0: begin
                    sz = $urandom();
                    a = $urandom_range(0, 31);
                end
                1: begin
                    sz = $urandom() >> $urandom_range(0, 31);
                    a = $urandom_range(0, 31);
                end
                default: begin
                    a = $urandom_range(0, c);
                    sz = (c == 0) ? $urandom_range(0, 1)
                                  : ((32'd1 << (c - 1)) + 1 +
                                     ($urandom() % (32'd1 << (c - 1))));
                end
            endcase
            rt = $urandom_range(0, 1);
            c = class_for(sz, a);
            s = $urandom_range(0, 1023);
            if (rt && c < NCLS && $urandom_range(0, 4) != 0) begin
                s = $urandom_range(0, capacity_of(c) - 1);
                for (int j = 0; j < capacity_of(c); j++) begin
                    if (slot_taken[c][(s + j) % capacity_of(c)]) begin
                        s = (s + j) % capacity_of(c);
                        break;
                    end
                end
            end
            send_request(rt, sz, a, s[SLOT_W-1:0], 0, '0);
            idle_gap();
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
